>>> sv/swhr_pkg.sv
// ----------------------------------------------------------------------------
// swhr_pkg
// Shared types, codes and constants of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhr_pkg;

	// number of data bits in one reading: five bytes, most significant first
	localparam int DATA_BITS = 40;

	// two handshake phases, then a low and a high phase per data bit
	localparam logic [6:0] NUM_PHASES = 7'(2 + 2 * DATA_BITS);

	// APB address width: five registers at byte addresses 4*i
	localparam int ADDR_W = 5;

	// register reset values
	localparam logic [15:0] START_LOW_RST = 16'd5000;
	localparam logic [15:0] HS_TMO_RST    = 16'd1000;
	localparam logic [9:0]  BIT_TMO_RST   = 10'd100;
	localparam logic [9:0]  ONE_THR_RST   = 10'd40;

	// divide by five as a multiply by a rounded-up reciprocal, exact below 2^19
	localparam logic [18:0] RECIP5       = 19'd419431;
	localparam int          RECIP5_SHIFT = 21;

	// Fahrenheit offset in fifths of a tenth: 32.0 degrees * 10 * 5
	localparam logic signed [19:0] F_OFFSET_HALF = 20'sd1600;

	typedef enum logic [2:0] {
		REG_START_LOW = 3'd0,
		REG_HS_TMO    = 3'd1,
		REG_BIT_TMO   = 3'd2,
		REG_ONE_THR   = 3'd3,
		REG_FAHR      = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_GOOD     = 2'd0,
		STAT_TIMEOUT  = 2'd1,
		STAT_CHECKSUM = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] start_low;
		logic [15:0] hs_tmo;
		logic [9:0]  bit_tmo;
		logic [9:0]  one_thr;
		logic        fahr;
	} cfg_t;

	// result of the control stage, before decoding
	typedef struct packed {
		logic                 drive;
		logic                 busy;
		logic                 done;
		logic                 tmo;
		logic [DATA_BITS-1:0] bits;
	} s1_t;

endpackage

>>> sv/swhr_regs.sv
// ----------------------------------------------------------------------------
// swhr_regs
// APB register file holding the reader's timing and scale settings.
// ----------------------------------------------------------------------------
module swhr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [swhr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output swhr_pkg::cfg_t             cfg
);
	import swhr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low <= START_LOW_RST;
			cfg_q.hs_tmo    <= HS_TMO_RST;
			cfg_q.bit_tmo   <= BIT_TMO_RST;
			cfg_q.one_thr   <= ONE_THR_RST;
			cfg_q.fahr      <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_START_LOW: cfg_q.start_low <= pwdata[15:0];
				REG_HS_TMO:    cfg_q.hs_tmo    <= pwdata[15:0];
				REG_BIT_TMO:   cfg_q.bit_tmo   <= pwdata[9:0];
				REG_ONE_THR:   cfg_q.one_thr   <= pwdata[9:0];
				REG_FAHR:      cfg_q.fahr      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// return the addressed register, zero beyond the list
	always_comb begin
		case (idx)
			REG_START_LOW: prdata = {16'd0, cfg_q.start_low};
			REG_HS_TMO:    prdata = {16'd0, cfg_q.hs_tmo};
			REG_BIT_TMO:   prdata = {22'd0, cfg_q.bit_tmo};
			REG_ONE_THR:   prdata = {22'd0, cfg_q.one_thr};
			REG_FAHR:      prdata = {31'd0, cfg_q.fahr};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

>>> sv/swhr_ctrl.sv
// ----------------------------------------------------------------------------
// swhr_ctrl
// Start pulse and phase timing: one tick per item, result into stage one.
// ----------------------------------------------------------------------------
module swhr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  swhr_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           req_type,
	input  logic           pin_level,
	output logic           s1_valid,
	input  logic           s2_ready,
	output swhr_pkg::s1_t  s1
);
	import swhr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_PHASE
	} state_t;

	state_t               st_q, st_n;
	logic [6:0]           phase_q, ph_n;
	logic                 seen_q, seen_n;
	logic [15:0]          cnt_q, cnt_n;
	logic [DATA_BITS-1:0] bits_q, bits_n;
	logic                 v_s1;
	s1_t                  res, res_s1;
	logic                 acc;

	// phase decode for the current sample and for a following phase
	logic        hs_a, match_a, hold_a, tmo_a, lim_b_zero;
	logic [15:0] lim_a, cnt_a, cnt_inc;
	logic [6:0]  ph_b, ph_c;
	logic [DATA_BITS-1:0] bits_lvl;
	logic        fin, fin_tmo;

	assign in_ready = !v_s1 || s2_ready;
	assign acc      = in_valid && in_ready;
	assign s1_valid = v_s1;
	assign s1       = res_s1;

	assign hs_a    = phase_q < 7'd2;
	assign lim_a   = hs_a ? cfg.hs_tmo : {6'd0, cfg.bit_tmo};
	assign match_a = pin_level == phase_q[0];
	assign hold_a  = !seen_q || match_a;
	assign cnt_a   = (!seen_q && match_a) ? 16'd0 : cnt_q;
	assign tmo_a   = cnt_a >= lim_a;
	assign cnt_inc = cnt_q + 16'd1;
	assign ph_b    = phase_q + 7'd1;
	assign ph_c    = phase_q + 7'd2;
	// the phase after a level change starts on this same sample
	assign lim_b_zero = (phase_q == 7'd0) ? (cfg.hs_tmo == 16'd0) : (cfg.bit_tmo == 10'd0);
	// close a high data phase with its measured time
	assign bits_lvl = (!hs_a && phase_q[0])
		? {bits_q[DATA_BITS-2:0], cnt_q > {6'd0, cfg.one_thr}} : bits_q;

	// next state and result of one item
	always_comb begin
		st_n    = st_q;
		ph_n    = phase_q;
		seen_n  = seen_q;
		cnt_n   = cnt_q;
		bits_n  = bits_q;
		fin     = 1'b0;
		fin_tmo = 1'b0;
		res     = '0;
		if (req_type) begin
			ph_n      = 7'd0;
			seen_n    = 1'b0;
			cnt_n     = 16'd0;
			bits_n    = '0;
			st_n      = (cfg.start_low != 16'd0) ? ST_START : ST_PHASE;
			res.drive = cfg.start_low != 16'd0;
			res.busy  = 1'b1;
		end else begin
			case (st_q)
				ST_START: begin
					res.busy = 1'b1;
					if (cnt_inc >= cfg.start_low) begin
						st_n  = ST_PHASE;
						cnt_n = 16'd0;
					end else begin
						cnt_n     = cnt_inc;
						res.drive = 1'b1;
					end
				end
				ST_PHASE: begin
					res.busy = 1'b1;
					if (hold_a) begin
						if (tmo_a) begin
							if (hs_a) begin
								fin     = 1'b1;
								fin_tmo = 1'b1;
							end else begin
								// timed-out data phase counts as zero
								if (phase_q[0]) begin
									bits_n = {bits_q[DATA_BITS-2:0], 1'b0};
								end
								ph_n   = ph_b;
								seen_n = 1'b0;
								cnt_n  = 16'd0;
								fin    = ph_b >= NUM_PHASES;
							end
						end else begin
							// count while waiting for the level as well as while it holds
							seen_n = seen_q || match_a;
							cnt_n  = cnt_a + 16'd1;
						end
					end else begin
						bits_n = bits_lvl;
						if (ph_b >= NUM_PHASES) begin
							fin = 1'b1;
						end else if (lim_b_zero) begin
							if (phase_q == 7'd0) begin
								fin     = 1'b1;
								fin_tmo = 1'b1;
							end else begin
								if (ph_b[0]) begin
									bits_n = {bits_lvl[DATA_BITS-2:0], 1'b0};
								end
								ph_n   = ph_c;
								seen_n = 1'b0;
								cnt_n  = 16'd0;
								fin    = ph_c >= NUM_PHASES;
							end
						end else begin
							ph_n   = ph_b;
							seen_n = 1'b1;
							cnt_n  = 16'd1;
						end
					end
				end
				default: st_n = ST_IDLE;
			endcase
		end
		// end of reading: back to idle, keep the bits for decoding
		if (fin) begin
			st_n     = ST_IDLE;
			ph_n     = 7'd0;
			seen_n   = 1'b0;
			cnt_n    = 16'd0;
			res.busy = 1'b0;
			res.done = 1'b1;
			res.tmo  = fin_tmo;
		end
		res.bits = bits_n;
	end

	// hold state and the stage-one result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= 7'd0;
			seen_q  <= 1'b0;
			cnt_q   <= 16'd0;
			bits_q  <= '0;
			v_s1    <= 1'b0;
			res_s1  <= '0;
		end else begin
			if (acc) begin
				st_q    <= st_n;
				phase_q <= ph_n;
				seen_q  <= seen_n;
				cnt_q   <= cnt_n;
				bits_q  <= bits_n;
				res_s1  <= res;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PHASE |-> phase_q < NUM_PHASES)
		else $error("phase index beyond last phase");

	a_rest_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_PHASE) |-> (phase_q == 7'd0 && !seen_q))
		else $error("phase state left over outside the timed phases");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.done) |=> (st_q == ST_IDLE && phase_q == 7'd0 && !seen_q))
		else $error("finished reading did not return to idle");

endmodule

>>> sv/swhr_conv.sv
// ----------------------------------------------------------------------------
// swhr_conv
// Decode the five bytes, check the sum and scale temperature to the output.
// ----------------------------------------------------------------------------
module swhr_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fahr,
	input  logic                s1_valid,
	output logic                s1_ready,
	input  swhr_pkg::s1_t       s1,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                drive_low,
	output logic                busy_res,
	output logic                done_res,
	output logic [1:0]          status,
	output logic [15:0]         humidity_tenths,
	output logic signed [16:0]  temperature_tenths
);
	import swhr_pkg::*;

	typedef struct packed {
		logic               drive;
		logic               busy;
		logic               done;
		status_t            stat;
		logic               meas;
		logic [15:0]        hum;
		logic signed [16:0] cel;
		logic               fneg;
		logic [18:0]        fx;
	} s2_t;

	s2_t                prep, s2_q;
	logic               v_s2, v_o;
	logic               en_o, en2;
	logic [7:0]         sum8;
	logic [14:0]        mag;
	logic signed [16:0] cel;
	logic signed [19:0] cel_x, w, w_abs;
	logic [37:0]        prod;
	logic [15:0]        fq;
	logic signed [16:0] temp_n;

	assign en_o     = !v_o || out_ready;
	assign en2      = !v_s2 || en_o;
	assign s1_ready = en2;
	assign out_valid = v_o;

	// split bytes, check sum, form Fahrenheit fifths of a tenth 9*C + 1600
	assign sum8  = s1.bits[39:32] + s1.bits[31:24] + s1.bits[23:16] + s1.bits[15:8];
	assign mag   = {s1.bits[22:16], s1.bits[15:8]};
	assign cel   = s1.bits[23] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
	assign cel_x = 20'(cel);
	assign w     = (cel_x <<< 3) + cel_x + F_OFFSET_HALF;
	assign w_abs = w[19] ? -w : w;

	always_comb begin
		prep.drive = s1.drive;
		prep.busy  = s1.busy;
		prep.done  = s1.done;
		prep.meas  = s1.done && !s1.tmo;
		prep.stat  = STAT_GOOD;
		if (s1.done) begin
			if (s1.tmo) begin
				prep.stat = STAT_TIMEOUT;
			end else if (sum8 != s1.bits[7:0]) begin
				prep.stat = STAT_CHECKSUM;
			end
		end
		prep.hum  = prep.meas ? s1.bits[39:24] : 16'd0;
		prep.cel  = prep.meas ? cel : 17'sd0;
		prep.fneg = w[19];
		// round to nearest: (|w| + 2) / 5
		prep.fx   = 19'(w_abs) + 19'd2;
	end

	// divide by five and apply the sign
	assign prod = 38'(s2_q.fx) * 38'(RECIP5);
	assign fq   = prod[RECIP5_SHIFT+15:RECIP5_SHIFT];
	assign temp_n = (fahr && s2_q.meas)
		? (s2_q.fneg ? -$signed({1'b0, fq}) : $signed({1'b0, fq})) : s2_q.cel;

	// advance stage two and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_o  <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= s1_valid;
			end
			if (en_o) begin
				v_o <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && s1_valid) begin
			s2_q <= prep;
		end
		if (en_o && v_s2) begin
			drive_low          <= s2_q.drive;
			busy_res           <= s2_q.busy;
			done_res           <= s2_q.done;
			status             <= s2_q.stat;
			humidity_tenths    <= s2_q.hum;
			temperature_tenths <= temp_n;
		end
	end

	a_tmo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_TIMEOUT) |->
			(humidity_tenths == 16'd0 && temperature_tenths == 17'sd0))
		else $error("timeout result carries measurement");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |->
			(status == STAT_GOOD && humidity_tenths == 16'd0 && temperature_tenths == 17'sd0))
		else $error("status or data without finished reading");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (!busy_res && !drive_low))
		else $error("finished reading still busy or driving");

endmodule

>>> sv/single_wire_humidity_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Single-wire humidity and temperature sensor reader, one tick per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item's result passes the control, decode and output
// registers, the scaling multiply before the last. Throughput: one item per
// cycle unless out_ready stalls it; a stalled output holds up to two more items.
// Reset: arst_n clears state to idle and registers to their reset values
// (5000, 1000, 100, 40, Celsius); no clearing pass is needed.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swhr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic                        pin_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        drive_low,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [1:0]                  status,
	output logic [15:0]                 humidity_tenths,
	output logic signed [16:0]          temperature_tenths
);
	import swhr_pkg::*;

	cfg_t cfg;
	s1_t  s1;
	logic s1_valid, s2_ready;

	// configuration registers
	swhr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tick timing and bit capture
	swhr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pin_level (pin_level),
		.s1_valid  (s1_valid),
		.s2_ready  (s2_ready),
		.s1        (s1)
	);

	// decode, checksum and scaling
	swhr_conv u_conv (
		.clk                (clk),
		.arst_n             (arst_n),
		.fahr               (cfg.fahr),
		.s1_valid           (s1_valid),
		.s1_ready           (s2_ready),
		.s1                 (s1),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.drive_low          (drive_low),
		.busy_res           (busy_res),
		.done_res           (done_res),
		.status             (status),
		.humidity_tenths    (humidity_tenths),
		.temperature_tenths (temperature_tenths)
	);

endmodule

>>> tb/humidity_reading_pkg.sv
// ----------------------------------------------------------------------------
// humidity_reading_pkg
// Scoreboard for the single-wire humidity sensor reader: keeps its own copy of
// the registers and the reading state, works out the expected result of every
// accepted tick or start request, and checks each result field by field.
// ----------------------------------------------------------------------------
package humidity_reading_pkg;

	import swhr_pkg::*;

	// one result transaction as seen on the output ports
	typedef struct packed {
		logic               drive;
		logic               busy;
		logic               done;
		status_t            status;
		logic [15:0]        humidity;
		logic signed [16:0] temperature;
	} reading_result_t;

	class reading_scoreboard;

		typedef enum logic [1:0] {
			CTL_IDLE,
			CTL_START,
			CTL_PHASE
		} ctl_t;

		cfg_t                   cfg;
		ctl_t                   ctl;
		logic [6:0]             phase;
		bit                     level_seen;
		logic [15:0]            ticks;
		logic [DATA_BITS-1:0]   bits;
		reading_result_t        expected_results[$];
		int unsigned            errors;

		function new();
			cfg.start_low = START_LOW_RST;
			cfg.hs_tmo = HS_TMO_RST;
			cfg.bit_tmo = BIT_TMO_RST;
			cfg.one_thr = ONE_THR_RST;
			cfg.fahr = 1'b0;
			ctl = CTL_IDLE;
			phase = '0;
			level_seen = 1'b0;
			ticks = '0;
			bits = '0;
			errors = 0;
		endfunction

		// Track a register write
		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
			REG_START_LOW: cfg.start_low = value[15:0];
			REG_HS_TMO:    cfg.hs_tmo = value[15:0];
			REG_BIT_TMO:   cfg.bit_tmo = value[9:0];
			REG_ONE_THR:   cfg.one_thr = value[9:0];
			REG_FAHR:      cfg.fahr = value[0];
			default: ;
			endcase
		endfunction

		// Decode the received frame and return to idle
		function reading_result_t finish_reading(bit timed_out);
			reading_result_t r;
			int              tenths;
			int              scaled;
			logic [7:0]      sum;
			r = '0;
			r.done = 1'b1;
			r.status = STAT_TIMEOUT;
			if (!timed_out) begin
				// sign-magnitude temperature; negative zero folds to zero
				tenths = int'(bits[22:8]);
				if (bits[23])
					tenths = -tenths;
				// Fahrenheit, rounded to nearest by magnitude
				if (cfg.fahr) begin
					scaled = tenths * 18 + 3200;
					tenths = (scaled >= 0) ? (scaled + 5) / 10 : -((-scaled + 5) / 10);
				end
				sum = bits[39:32] + bits[31:24] + bits[23:16] + bits[15:8];
				r.humidity = bits[39:24];
				r.temperature = tenths[16:0];
				r.status = (bits[7:0] == sum) ? STAT_GOOD : STAT_CHECKSUM;
			end
			ctl = CTL_IDLE;
			phase = '0;
			level_seen = 1'b0;
			ticks = '0;
			return r;
		endfunction

		// Close a phase; shift in a bit after each data high phase
		function bit close_phase(logic [15:0] duration);
			if (phase >= 7'd2 && phase[0])
				bits = {bits[DATA_BITS-2:0], duration > {6'd0, cfg.one_thr}};
			phase = phase + 7'd1;
			level_seen = 1'b0;
			ticks = '0;
			return phase >= NUM_PHASES;
		endfunction

		// One line sample during the timed phases
		function reading_result_t phase_tick(bit pin);
			reading_result_t r;
			bit              level_wanted;
			logic [15:0]     limit;
			bit              settled;
			r = '0;
			r.busy = 1'b1;
			settled = 1'b0;
			while (!settled) begin
				// handshake is low then high; each data bit is low then high
				if (phase < 7'd2)
					level_wanted = phase[0];
				else
					level_wanted = phase[0];
				limit = (phase < 7'd2) ? cfg.hs_tmo : {6'd0, cfg.bit_tmo};
				if (!level_seen && pin == level_wanted) begin
					level_seen = 1'b1;
					ticks = '0;
				end
				if (!level_seen || pin == level_wanted) begin
					settled = 1'b1;
					if (ticks >= limit) begin
						// handshake timeout aborts; bit timeout counts as zero duration
						if (phase < 7'd2)
							r = finish_reading(1'b1);
						else if (close_phase(16'd0))
							r = finish_reading(1'b0);
					end else begin
						ticks = ticks + 16'd1;
					end
				end else if (close_phase(ticks)) begin
					// level changed: the same sample opens the next phase
					settled = 1'b1;
					r = finish_reading(1'b0);
				end
			end
			return r;
		endfunction

		// Note an accepted item and queue its expected result
		function void note_item(bit req, bit pin);
			reading_result_t r;
			r = '0;
			if (req) begin
				// start, or restart while busy
				phase = '0;
				level_seen = 1'b0;
				ticks = '0;
				bits = '0;
				ctl = (cfg.start_low != 16'd0) ? CTL_START : CTL_PHASE;
				r.drive = (ctl == CTL_START);
				r.busy = 1'b1;
			end else if (ctl == CTL_START) begin
				ticks = ticks + 16'd1;
				r.busy = 1'b1;
				if (ticks >= cfg.start_low) begin
					ctl = CTL_PHASE;
					ticks = '0;
				end else begin
					r.drive = 1'b1;
				end
			end else if (ctl == CTL_PHASE) begin
				r = phase_tick(pin);
			end
			expected_results.push_back(r);
		endfunction

		// Compare a result with the oldest expectation
		function void check_result(reading_result_t got);
			reading_result_t exp_r;
			if (expected_results.size() == 0) begin
				$error("result transaction with no expected result waiting");
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.drive !== exp_r.drive) begin
				$error("drive_low: expected %0d, got %0d", exp_r.drive, got.drive);
				errors++;
			end
			if (got.busy !== exp_r.busy) begin
				$error("busy_res: expected %0d, got %0d", exp_r.busy, got.busy);
				errors++;
			end
			if (got.done !== exp_r.done) begin
				$error("done_res: expected %0d, got %0d", exp_r.done, got.done);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.humidity !== exp_r.humidity) begin
				$error("humidity_tenths: expected %0d, got %0d", exp_r.humidity, got.humidity);
				errors++;
			end
			if (got.temperature !== exp_r.temperature) begin
				$error("temperature_tenths: expected %0d, got %0d",
					exp_r.temperature, got.temperature);
				errors++;
			end
		endfunction

	endclass

endpackage

>>> tb/single_wire_humidity_sensor_reader_test.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_test
// Drives ticks and start requests into the reader with random idling on both
// sides, emulates a sensor answering on the line, and checks every result
// against the scoreboard across several register settings.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_test;

	timeunit 1ns;
	timeprecision 1ps;

	import swhr_pkg::*;
	import humidity_reading_pkg::*;

	// slowest run: about 1100 items, each with its longest gap, its longest stall
	// and the pipeline, plus drains and a long hold; taken several times over
	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic                 pin_level;
	logic                 out_valid;
	logic                 out_ready;
	logic                 drive_low;
	logic                 busy_res;
	logic                 done_res;
	logic [1:0]           status;
	logic [15:0]          humidity_tenths;
	logic signed [16:0]   temperature_tenths;

	reading_scoreboard    readings;
	bit                   quiet_tail;
	bit                   long_hold_request;
	int                   cycles;

	single_wire_humidity_sensor_reader uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.req_type           (req_type),
		.pin_level          (pin_level),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.drive_low          (drive_low),
		.busy_res           (busy_res),
		.done_res           (done_res),
		.status             (status),
		.humidity_tenths    (humidity_tenths),
		.temperature_tenths (temperature_tenths)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Check every result transaction
	always @(posedge clk) begin
		reading_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.drive = drive_low;
			got.busy = busy_res;
			got.done = done_res;
			got.status = status_t'(status);
			got.humidity = humidity_tenths;
			got.temperature = temperature_tenths;
			readings.check_result(got);
		end
	end

	// Receiver: random stall bursts, one long hold on request, none in the tail
	initial begin
		int burst;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (200) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Abort a hung run
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("single_wire_humidity_sensor_reader regression: fail");
		$finish;
	end

	// Offer one item and hold it until the transaction completes
	task automatic send_item(bit req, bit pin);
		int gap;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		pin_level <= pin;
		do
			@(posedge clk);
		while (!in_ready);
		readings.note_item(req, pin);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (readings.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readings.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reprogram every register once the block has drained
	task automatic apply_settings(int start_low, int hs, int bt, int thr, bit fahr);
		wait_drained();
		write_reg(REG_START_LOW, 32'(start_low));
		write_reg(REG_HS_TMO, 32'(hs));
		write_reg(REG_BIT_TMO, 32'(bt));
		write_reg(REG_ONE_THR, 32'(thr));
		write_reg(REG_FAHR, 32'(fahr));
	endtask

	function automatic int spread(int top);
		return $urandom_range(1, (top < 1) ? 1 : top);
	endfunction

	// Handshake phase length, now and then past the limit
	function automatic int handshake_len();
		int hs;
		hs = int'(readings.cfg.hs_tmo);
		if (hs < 16 && $urandom_range(0, 9) == 0)
			return hs + $urandom_range(1, 3);
		return spread((hs < 4) ? hs : 4);
	endfunction

	// Data bit phase length; a one is held just above a threshold below 16
	function automatic int bit_len(bit high, bit value);
		int bt;
		int thr;
		bt = int'(readings.cfg.bit_tmo);
		thr = int'(readings.cfg.one_thr);
		if (bt < 16 && $urandom_range(0, 24) == 0)
			return bt + $urandom_range(1, 2);
		if (!high)
			return spread((bt < 3) ? bt : 3);
		if (value && thr < 16)
			return thr + $urandom_range(1, 2);
		return spread((thr < 3) ? thr : 3);
	endfunction

	// Humidity and temperature words, biased towards the awkward ones
	function automatic logic [31:0] pick_payload();
		case ($urandom_range(0, 7))
		0: return {16'($urandom), 16'h8000};    // negative zero
		1: return {16'hFFFF, 16'h7FFF};         // hottest, wettest
		2: return {16'($urandom), 16'hFFFF};    // coldest
		3: return 32'h0;
		default: return $urandom;
		endcase
	endfunction

	// Emulate one sensor reading: start, release, handshake, 40 bits, end
	task automatic run_reading(bit sum_ok, bit cut_short, int pause_at);
		logic [31:0] payload;
		logic [7:0]  sum;
		logic [39:0] frame;
		bit          line[$];
		int          total;
		int          k;
		payload = pick_payload();
		sum = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
		if (!sum_ok)
			sum = sum ^ 8'($urandom_range(1, 255));
		frame = {payload, sum};
		// line level is ignored while the block drives it low
		for (k = 0; k < int'(readings.cfg.start_low); k++)
			line.push_back(1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 2)) line.push_back(1'b1);
		repeat (handshake_len()) line.push_back(1'b0);
		repeat (handshake_len()) line.push_back(1'b1);
		for (k = 39; k >= 0; k--) begin
			repeat (bit_len(1'b0, 1'b0)) line.push_back(1'b0);
			repeat (bit_len(1'b1, frame[k])) line.push_back(1'b1);
		end
		repeat ($urandom_range(1, 3)) line.push_back(1'b0);
		repeat ($urandom_range(1, 4)) line.push_back(1'b1);
		// a broken reading stops part way and is left to the next start
		total = cut_short ? $urandom_range(0, line.size() - 1) : line.size();
		send_item(1'b1, 1'($urandom_range(0, 1)));
		for (k = 0; k < total; k++) begin
			if (k == pause_at)
				wait_drained();
			send_item(1'b0, line[k]);
		end
	endtask

	// A batch of readings with some noise in between
	task automatic run_phase(int count, bit pause_once);
		int r;
		for (r = 0; r < count; r++) begin
			run_reading($urandom_range(0, 6) != 0, $urandom_range(0, 9) == 0,
				(pause_once && r == 0) ? 40 : -1);
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3))
					send_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
		end
	endtask

	// Main sequence
	initial begin
		int i;
		int thr;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		pin_level = 1'b0;
		quiet_tail = 1'b0;
		long_hold_request = 1'b0;
		readings = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ticks while idle, start, restart while busy
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);

		// zero start time and a zero handshake limit: immediate timeout
		apply_settings(0, 0, 1, 0, 0);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);

		// line stuck high until the handshake limit runs out
		apply_settings(1, 3, 0, 1023, 1);
		send_item(1'b1, 1'b1);
		repeat (6) send_item(1'b0, 1'b1);

		// readings, some with a bad sum or cut short; one long receiver hold and one sender pause
		apply_settings(2, 12, 8, 2, 0);
		run_phase(1, 1'b0);
		apply_settings(0, 20, 10, 3, 1);
		long_hold_request = 1'b1;
		run_phase(1, 1'b1);

		// largest limits, then the smallest
		apply_settings(3, 65535, 1023, 1023, 1);
		run_phase(1, 1'b0);
		apply_settings(0, 1, 0, 0, 0);
		run_phase(1, 1'b0);

		// random settings
		for (i = 0; i < 1; i++) begin
			thr = $urandom_range(0, 4);
			apply_settings($urandom_range(0, 4), $urandom_range(4, 24),
				$urandom_range(thr + 3, 12), thr, 1'($urandom_range(0, 1)));
			run_phase(1, 1'b0);
		end

		// tail with no idling on either side
		thr = $urandom_range(0, 4);
		apply_settings($urandom_range(0, 4), $urandom_range(4, 24),
			$urandom_range(thr + 3, 12), thr, 1'($urandom_range(0, 1)));
		quiet_tail = 1'b1;
		run_phase(1, 1'b0);

		wait_drained();
		repeat (6) @(posedge clk);
		if (readings.errors == 0)
			$display("single_wire_humidity_sensor_reader regression: pass");
		else
			$display("single_wire_humidity_sensor_reader regression: fail");
		$finish;
	end

endmodule
